/* hdl/onewire_temp_sensor_poller_macros.svh */
// Assertion macros for the one-wire temperature sensor poller
`ifndef ONEWIRE_TEMP_SENSOR_POLLER_MACROS_SVH
`define ONEWIRE_TEMP_SENSOR_POLLER_MACROS_SVH
`define OW_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define OW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hdl/owtsp_pkg.sv */
// Shared types and constants for the one-wire temperature sensor poller
package owtsp_pkg;
   typedef struct packed {
      logic line_level;
      logic tank_level;
   } req_type;

   typedef struct packed {
      logic              pull_low;
      logic              water_seen;
      logic              sensor_present;
      logic              temp_valid;
      logic signed [15:0] temp_value;
      logic [1:0]        last_status;
      logic              changed;
      logic              busy_res;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ticks_per_ms;
      logic [15:0] conversion_wait_ms;
      logic [15:0] retry_period_ms;
      logic [15:0] temp_high_limit;
      logic [15:0] temp_low_limit;
      logic [15:0] invalid_temp_code;
   } cfg_type;

   localparam logic [2:0] REG_TICKS   = 3'd0;
   localparam logic [2:0] REG_WAIT    = 3'd1;
   localparam logic [2:0] REG_RETRY   = 3'd2;
   localparam logic [2:0] REG_HIGH    = 3'd3;
   localparam logic [2:0] REG_LOW     = 3'd4;
   localparam logic [2:0] REG_INVALID = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_PRES = 2'd1;
   localparam logic [1:0] ST_CRC     = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   localparam logic [15:0] TEMP_INVALID_RESET = 16'h8000;

   localparam logic [7:0] CRC_POLY     = 8'h8C;
   localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   localparam logic [9:0] RST_LOW_TICKS  = 10'd750;
   localparam logic [9:0] RST_GAP_TICKS  = 10'd15;
   localparam logic [9:0] RST_WAIT_TICKS = 10'd200;
   localparam logic [9:0] RST_HOLD_TICKS = 10'd240;
   localparam logic [9:0] WR_SLOT_TICKS  = 10'd70;
   localparam logic [9:0] WR_ONE_LOW     = 10'd6;
   localparam logic [9:0] WR_ZERO_LOW    = 10'd60;
   localparam logic [9:0] RD_SLOT_TICKS  = 10'd66;
   localparam logic [9:0] RD_LOW_TICKS   = 10'd3;
   localparam logic [9:0] RD_SAMPLE_AT   = 10'd15;
   localparam logic [3:0] LAST_BYTE      = 4'd8;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_RST_LOW  = 8'b0000_0010,
      PH_RST_GAP  = 8'b0000_0100,
      PH_RST_WAIT = 8'b0000_1000,
      PH_RST_HOLD = 8'b0001_0000,
      PH_WR_SKIP  = 8'b0010_0000,
      PH_WR_CMD   = 8'b0100_0000,
      PH_RD_DATA  = 8'b1000_0000
   } phase_type;
endpackage

/* hdl/owtsp_csr.sv */
// Configuration register file
module owtsp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output owtsp_pkg::cfg_type   cfg
);
   owtsp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            owtsp_pkg::REG_TICKS:   cfg_in.ticks_per_ms       = csr_data;
            owtsp_pkg::REG_WAIT:    cfg_in.conversion_wait_ms = csr_data;
            owtsp_pkg::REG_RETRY:   cfg_in.retry_period_ms    = csr_data;
            owtsp_pkg::REG_HIGH:    cfg_in.temp_high_limit    = csr_data;
            owtsp_pkg::REG_LOW:     cfg_in.temp_low_limit     = csr_data;
            owtsp_pkg::REG_INVALID: cfg_in.invalid_temp_code  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd1000, 16'd750, 16'd1000, 16'd1250, 16'hFDDA, 16'h8000};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

/* hdl/owtsp_core.sv */
// One-wire bus sequencer: millisecond timebase, poll, slots, CRC and scaling
module owtsp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  owtsp_pkg::req_type   req,
   input  owtsp_pkg::cfg_type   cfg,
   output owtsp_pkg::rsp_type   rsp
);
   owtsp_pkg::phase_type phase_ff, phase_in;
   logic [9:0]  slot_ff, slot_in;
   logic [15:0] tick_ff, tick_in;
   logic [31:0] ms_ff, ms_in, last_ff, last_in, conv_ff, conv_in;
   logic        active_ff, active_in;
   logic [2:0]  bit_ff, bit_in;
   logic [3:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in, crc_ff, crc_in;
   logic [15:0] raw_ff, raw_in;
   logic        water_ff, water_in, present_ff, present_in, valid_ff, valid_in;
   logic [15:0] temp_ff, temp_in;
   logic [1:0]  status_ff, status_in;
   logic [16:0] tick_next;
   logic [9:0]  slot_inc, low_len;
   logic        chg, pull, busy, line;
   logic signed [19:0] prod;
   logic signed [15:0] tenths;
   logic [7:0]  shift_rd, crc_rd;
   logic [15:0] raw_rd;

   assign line = req.line_level;
   assign slot_inc = slot_ff + 10'd1;
   assign tick_next = {1'b0, tick_ff} + 17'd1;
   assign low_len = shift_ff[0] ? owtsp_pkg::WR_ONE_LOW : owtsp_pkg::WR_ZERO_LOW;

   always_comb begin
      phase_in = phase_ff; slot_in = slot_ff; tick_in = tick_ff; ms_in = ms_ff;
      last_in = last_ff; conv_in = conv_ff; active_in = active_ff; bit_in = bit_ff;
      byte_in = byte_ff; shift_in = shift_ff; crc_in = crc_ff; raw_in = raw_ff;
      water_in = water_ff; present_in = present_ff; valid_in = valid_ff;
      temp_in = temp_ff; status_in = status_ff;
      chg = 1'b0; pull = 1'b0;
      shift_rd = shift_ff; crc_rd = crc_ff; raw_rd = raw_ff;
      prod = 20'sd0; tenths = 16'sd0;

      if (tick_next >= {1'b0, cfg.ticks_per_ms}) begin
         tick_in = '0;
         ms_in = ms_ff + 32'd1;
         if (req.tank_level != water_ff) begin
            water_in = req.tank_level;
            chg = 1'b1;
         end
         if (phase_ff == owtsp_pkg::PH_IDLE) begin
            if (active_ff && (ms_in - conv_ff) >= {16'd0, cfg.conversion_wait_ms}) begin
               last_in = ms_in;
               phase_in = owtsp_pkg::PH_RST_LOW;
               slot_in = '0;
            end else if (!active_ff &&
                         (ms_in - last_ff) >= {16'd0, cfg.retry_period_ms}) begin
               last_in = ms_in;
               conv_in = ms_in;
               phase_in = owtsp_pkg::PH_RST_LOW;
               slot_in = '0;
            end
         end
      end else begin
         tick_in = tick_next[15:0];
      end

      busy = (phase_in != owtsp_pkg::PH_IDLE);

      unique case (phase_in)
         owtsp_pkg::PH_IDLE: ;
         owtsp_pkg::PH_RST_LOW: begin
            pull = 1'b1;
            slot_in = slot_in + 10'd1;
            if (slot_in >= owtsp_pkg::RST_LOW_TICKS) begin
               slot_in = '0; phase_in = owtsp_pkg::PH_RST_GAP;
            end
         end
         owtsp_pkg::PH_RST_GAP: begin
            slot_in = slot_inc;
            if (slot_inc >= owtsp_pkg::RST_GAP_TICKS) begin
               slot_in = '0; phase_in = owtsp_pkg::PH_RST_WAIT;
            end
         end
         owtsp_pkg::PH_RST_WAIT, owtsp_pkg::PH_RST_HOLD: begin
            if (phase_ff == owtsp_pkg::PH_RST_WAIT && !line) begin
               slot_in = 10'd1; phase_in = owtsp_pkg::PH_RST_HOLD;
            end else if (phase_ff == owtsp_pkg::PH_RST_HOLD && line) begin
               slot_in = '0; shift_in = owtsp_pkg::CMD_SKIP_ROM; bit_in = '0;
               phase_in = owtsp_pkg::PH_WR_SKIP;
            end else begin
               slot_in = slot_inc;
               if (slot_inc >= ((phase_ff == owtsp_pkg::PH_RST_WAIT) ?
                     owtsp_pkg::RST_WAIT_TICKS : owtsp_pkg::RST_HOLD_TICKS)) begin
                  slot_in = '0; present_in = 1'b0; valid_in = 1'b0;
                  temp_in = cfg.invalid_temp_code; status_in = owtsp_pkg::ST_NO_PRES;
                  if (active_ff) begin
                     active_in = 1'b0; chg = 1'b1;
                  end
                  phase_in = owtsp_pkg::PH_IDLE;
               end
            end
         end
         owtsp_pkg::PH_WR_SKIP, owtsp_pkg::PH_WR_CMD: begin
            pull = slot_ff < low_len;
            slot_in = slot_inc;
            if (slot_inc >= owtsp_pkg::WR_SLOT_TICKS) begin
               slot_in = '0;
               shift_in = {1'b0, shift_ff[7:1]};
               if (bit_ff == 3'd7) begin
                  bit_in = '0;
                  if (phase_ff == owtsp_pkg::PH_WR_SKIP) begin
                     shift_in = active_ff ? owtsp_pkg::CMD_READ_PAD : owtsp_pkg::CMD_CONVERT;
                     phase_in = owtsp_pkg::PH_WR_CMD;
                  end else if (active_ff) begin
                     byte_in = '0; crc_in = '0; raw_in = '0;
                     phase_in = owtsp_pkg::PH_RD_DATA;
                  end else begin
                     active_in = 1'b1; present_in = 1'b1;
                     phase_in = owtsp_pkg::PH_IDLE;
                  end
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
         end
         owtsp_pkg::PH_RD_DATA: begin
            pull = slot_ff < owtsp_pkg::RD_LOW_TICKS;
            if (slot_ff == owtsp_pkg::RD_SAMPLE_AT) begin
               shift_rd = {line, shift_ff[7:1]};
               if (byte_ff < owtsp_pkg::LAST_BYTE) begin
                  crc_rd = {1'b0, crc_ff[7:1]} ^
                           (((crc_ff[0] ^ line)) ? owtsp_pkg::CRC_POLY : 8'h00);
               end
            end
            shift_in = shift_rd; crc_in = crc_rd;
            slot_in = slot_inc;
            if (slot_inc >= owtsp_pkg::RD_SLOT_TICKS) begin
               slot_in = '0;
               if (bit_ff == 3'd7) begin
                  bit_in = '0;
                  if (byte_ff == 4'd0) raw_rd = {raw_ff[15:8], shift_rd};
                  else if (byte_ff == 4'd1) raw_rd = {shift_rd, raw_ff[7:0]};
                  raw_in = raw_rd;
                  if (byte_ff >= owtsp_pkg::LAST_BYTE) begin
                     prod = 20'(signed'(raw_rd)) * 20'sd10;
                     tenths = 16'((prod + ((prod < 0) ? 20'sd15 : 20'sd0)) >>> 4);
                     active_in = 1'b0;
                     phase_in = owtsp_pkg::PH_IDLE;
                     if (shift_rd != crc_rd) status_in = owtsp_pkg::ST_CRC;
                     else if (tenths > signed'(cfg.temp_high_limit) ||
                              tenths < signed'(cfg.temp_low_limit))
                        status_in = owtsp_pkg::ST_RANGE;
                     else status_in = owtsp_pkg::ST_OK;
                     if (status_in == owtsp_pkg::ST_OK) begin
                        if (!valid_ff || temp_ff != tenths) chg = 1'b1;
                        present_in = 1'b1; valid_in = 1'b1; temp_in = tenths;
                     end else begin
                        valid_in = 1'b0; temp_in = cfg.invalid_temp_code; chg = 1'b1;
                     end
                  end else begin
                     byte_in = byte_ff + 4'd1;
                  end
               end else begin
                  bit_in = bit_ff + 3'd1;
               end
            end
         end
         default: phase_in = owtsp_pkg::PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owtsp_pkg::PH_IDLE; slot_ff <= '0; tick_ff <= '0; ms_ff <= '0;
         last_ff <= '0; conv_ff <= '0; active_ff <= 1'b0; bit_ff <= '0; byte_ff <= '0;
         shift_ff <= '0; crc_ff <= '0; raw_ff <= '0; water_ff <= 1'b0;
         present_ff <= 1'b0; valid_ff <= 1'b0; temp_ff <= owtsp_pkg::TEMP_INVALID_RESET;
         status_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; slot_ff <= slot_in; tick_ff <= tick_in; ms_ff <= ms_in;
         last_ff <= last_in; conv_ff <= conv_in; active_ff <= active_in;
         bit_ff <= bit_in; byte_ff <= byte_in; shift_ff <= shift_in; crc_ff <= crc_in;
         raw_ff <= raw_in; water_ff <= water_in; present_ff <= present_in;
         valid_ff <= valid_in; temp_ff <= temp_in; status_ff <= status_in;
      end
   end

   always_comb begin
      rsp.pull_low = pull;
      rsp.water_seen = water_in;
      rsp.sensor_present = present_in;
      rsp.temp_valid = valid_in;
      rsp.temp_value = temp_in;
      rsp.last_status = status_in;
      rsp.changed = chg;
      rsp.busy_res = busy;
   end

`include "onewire_temp_sensor_poller_macros.svh"
   `OW_ASSERT_IMPL(a_phase_onehot, clock, reset, 1'b1, $onehot(phase_ff))
   `OW_ASSERT_IMPL(a_valid_present, clock, reset, valid_ff, present_ff)
   `OW_ASSERT_IMPL(a_read_active, clock, reset, phase_ff == owtsp_pkg::PH_RD_DATA, active_ff)
   `OW_ASSERT_NEXT(a_hold, clock, reset, !step, $stable(phase_ff) && $stable(ms_ff))
endmodule

/* hdl/onewire_temp_sensor_poller.sv */
// Top level of the one-wire temperature sensor poller
// Usage:
//   Each req transaction is one microsecond tick carrying the sampled one-wire
//   line and the tank-level pin. Each tick yields exactly one rsp transaction
//   with the line drive, water and sensor flags, temperature in tenths of a
//   degree, status and a one-tick changed pulse. A tick's result is registered
//   and shown on rsp the cycle after acceptance. The sequencer state and the
//   output register advance together in a single pass, one tick per cycle
//   while rsp is not stalled. When rsp is stalled, the held result stays and
//   req is stalled too until the output register drains; a new tick is taken
//   in the cycle it frees. The csr port writes registers 0..5 (ticks per ms,
//   conversion wait, retry period, high and low limit, invalid code); the user
//   must write them only while the block is idle, which it does not enforce.
//   Reset (synchronous, active high) restores register defaults, idles the
//   bus, clears all flags and loads the invalid code as the temperature.
module onewire_temp_sensor_poller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  owtsp_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output owtsp_pkg::rsp_type   rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data
);
   owtsp_pkg::cfg_type cfg;
   owtsp_pkg::rsp_type result, rsp_ff;
   logic               valid_ff, step;

   assign req_stall = valid_ff && rsp_stall;
   assign step = req_valid && !req_stall;

   owtsp_csr u_csr (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .cfg
   );

   owtsp_core u_core (
      .clock, .reset, .step, .req(req_data), .cfg, .rsp(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;
endmodule

/* bench/onewire_temp_sensor_poller_checker.sv */
// Predicting scoreboard for the one-wire temperature sensor poller
module onewire_temp_sensor_poller_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  owtsp_pkg::req_type   req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  owtsp_pkg::rsp_type   rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   output int                   mismatch_count,
   output int                   pending_count,
   output owtsp_pkg::phase_type bus_phase_view,
   output logic [3:0]           byte_view,
   output logic [2:0]           bit_view
);
   owtsp_pkg::cfg_type   cfg;
   owtsp_pkg::phase_type phase;
   int unsigned slot_timer, tick_in_ms, bit_index, pad_byte_num;
   bit [31:0]   ms_now, last_attempt_ms, conversion_start_ms;
   bit [7:0]    shift_byte, crc_acc;
   bit [15:0]   raw_temp, temp_reg;
   bit          conversion_active, presence_seen, water_flag, present_flag, valid_flag;
   bit [1:0]    status_reg;
   bit          changed_now;
   owtsp_pkg::rsp_type expected_ticks[$];

   task automatic clear_poller();
      cfg.ticks_per_ms       = 16'd1000;
      cfg.conversion_wait_ms = 16'd750;
      cfg.retry_period_ms    = 16'd1000;
      cfg.temp_high_limit    = 16'd1250;
      cfg.temp_low_limit     = -16'sd550;
      cfg.invalid_temp_code  = 16'h8000;
      phase = owtsp_pkg::PH_IDLE;
      slot_timer = 0; tick_in_ms = 0; bit_index = 0; pad_byte_num = 0;
      ms_now = 0; last_attempt_ms = 0; conversion_start_ms = 0;
      shift_byte = 0; crc_acc = 0; raw_temp = 0;
      temp_reg = cfg.invalid_temp_code;
      conversion_active = 0; presence_seen = 0; water_flag = 0;
      present_flag = 0; valid_flag = 0; status_reg = owtsp_pkg::ST_OK; changed_now = 0;
   endtask

   task automatic drop_reading();
      valid_flag = 0;
      temp_reg = cfg.invalid_temp_code;
   endtask

   task automatic end_bus_reset(input bit ok);
      slot_timer = 0;
      if (!ok) begin
         presence_seen = 0;
         present_flag = 0;
         drop_reading();
         status_reg = owtsp_pkg::ST_NO_PRES;
         if (conversion_active) begin
            conversion_active = 0;
            changed_now = 1;
         end
         phase = owtsp_pkg::PH_IDLE;
      end else begin
         shift_byte = owtsp_pkg::CMD_SKIP_ROM;
         bit_index = 0;
         phase = owtsp_pkg::PH_WR_SKIP;
      end
   endtask

   task automatic score_reading();
      int       tenths;
      bit [1:0] st;
      tenths = int'($signed(raw_temp)) * 10 / 16;
      st = owtsp_pkg::ST_OK;
      if (shift_byte != crc_acc)
         st = owtsp_pkg::ST_CRC;
      else if (tenths > int'($signed(cfg.temp_high_limit)) ||
               tenths < int'($signed(cfg.temp_low_limit)))
         st = owtsp_pkg::ST_RANGE;
      conversion_active = 0;
      status_reg = st;
      if (st == owtsp_pkg::ST_OK) begin
         if (!valid_flag || temp_reg != tenths[15:0]) changed_now = 1;
         present_flag = 1;
         valid_flag = 1;
         temp_reg = tenths[15:0];
      end else begin
         drop_reading();
         changed_now = 1;
      end
      phase = owtsp_pkg::PH_IDLE;
   endtask

   task automatic command_sent();
      bit_index = 0;
      if (phase == owtsp_pkg::PH_WR_SKIP) begin
         shift_byte = conversion_active ? owtsp_pkg::CMD_READ_PAD : owtsp_pkg::CMD_CONVERT;
         phase = owtsp_pkg::PH_WR_CMD;
      end else if (conversion_active) begin
         pad_byte_num = 0;
         crc_acc = 0;
         raw_temp = 0;
         phase = owtsp_pkg::PH_RD_DATA;
      end else begin
         conversion_active = 1;
         present_flag = 1;
         phase = owtsp_pkg::PH_IDLE;
      end
   endtask

   task automatic pad_byte_read();
      bit_index = 0;
      if (pad_byte_num == 0) raw_temp[7:0] = shift_byte;
      else if (pad_byte_num == 1) raw_temp[15:8] = shift_byte;
      if (pad_byte_num >= owtsp_pkg::LAST_BYTE) score_reading();
      else pad_byte_num++;
   endtask

   task automatic advance_tick(input owtsp_pkg::req_type item,
                               output owtsp_pkg::rsp_type r);
      bit          pull, busy, mix;
      int unsigned t;
      pull = 0;
      changed_now = 0;
      t = tick_in_ms + 1;
      if (t >= cfg.ticks_per_ms) begin
         tick_in_ms = 0;
         ms_now++;
         if (item.tank_level != water_flag) begin
            water_flag = item.tank_level;
            changed_now = 1;
         end
         if (phase == owtsp_pkg::PH_IDLE) begin
            if (conversion_active &&
                ms_now - conversion_start_ms >= {16'd0, cfg.conversion_wait_ms}) begin
               last_attempt_ms = ms_now;
               phase = owtsp_pkg::PH_RST_LOW; slot_timer = 0; presence_seen = 0;
            end else if (!conversion_active &&
                         ms_now - last_attempt_ms >= {16'd0, cfg.retry_period_ms}) begin
               last_attempt_ms = ms_now;
               conversion_start_ms = ms_now;
               phase = owtsp_pkg::PH_RST_LOW; slot_timer = 0; presence_seen = 0;
            end
         end
      end else begin
         tick_in_ms = t;
      end
      busy = (phase != owtsp_pkg::PH_IDLE);
      case (phase)
         owtsp_pkg::PH_RST_LOW: begin
            pull = 1;
            slot_timer++;
            if (slot_timer >= owtsp_pkg::RST_LOW_TICKS) begin
               slot_timer = 0; phase = owtsp_pkg::PH_RST_GAP;
            end
         end
         owtsp_pkg::PH_RST_GAP: begin
            slot_timer++;
            if (slot_timer >= owtsp_pkg::RST_GAP_TICKS) begin
               slot_timer = 0; phase = owtsp_pkg::PH_RST_WAIT;
            end
         end
         owtsp_pkg::PH_RST_WAIT: begin
            if (!item.line_level) begin
               presence_seen = 1; slot_timer = 1; phase = owtsp_pkg::PH_RST_HOLD;
            end else begin
               slot_timer++;
               if (slot_timer >= owtsp_pkg::RST_WAIT_TICKS) end_bus_reset(0);
            end
         end
         owtsp_pkg::PH_RST_HOLD: begin
            if (item.line_level) end_bus_reset(1);
            else begin
               slot_timer++;
               if (slot_timer >= owtsp_pkg::RST_HOLD_TICKS) end_bus_reset(0);
            end
         end
         owtsp_pkg::PH_WR_SKIP, owtsp_pkg::PH_WR_CMD: begin
            pull = slot_timer < (shift_byte[0] ? owtsp_pkg::WR_ONE_LOW : owtsp_pkg::WR_ZERO_LOW);
            slot_timer++;
            if (slot_timer >= owtsp_pkg::WR_SLOT_TICKS) begin
               slot_timer = 0;
               shift_byte = shift_byte >> 1;
               if (bit_index >= 7) command_sent(); else bit_index++;
            end
         end
         owtsp_pkg::PH_RD_DATA: begin
            pull = slot_timer < owtsp_pkg::RD_LOW_TICKS;
            if (slot_timer == owtsp_pkg::RD_SAMPLE_AT) begin
               shift_byte = {item.line_level, shift_byte[7:1]};
               if (pad_byte_num < owtsp_pkg::LAST_BYTE) begin
                  mix = crc_acc[0] ^ item.line_level;
                  crc_acc = crc_acc >> 1;
                  if (mix) crc_acc = crc_acc ^ owtsp_pkg::CRC_POLY;
               end
            end
            slot_timer++;
            if (slot_timer >= owtsp_pkg::RD_SLOT_TICKS) begin
               slot_timer = 0;
               if (bit_index >= 7) pad_byte_read(); else bit_index++;
            end
         end
         default: phase = owtsp_pkg::PH_IDLE;
      endcase
      r.pull_low       = pull;
      r.water_seen     = water_flag;
      r.sensor_present = present_flag;
      r.temp_valid     = valid_flag;
      r.temp_value     = temp_reg;
      r.last_status    = status_reg;
      r.changed        = changed_now;
      r.busy_res       = busy;
   endtask

   always @(posedge clock) begin
      owtsp_pkg::rsp_type want;
      if (reset) begin
         clear_poller();
         expected_ticks.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               owtsp_pkg::REG_TICKS:   cfg.ticks_per_ms       = csr_data;
               owtsp_pkg::REG_WAIT:    cfg.conversion_wait_ms = csr_data;
               owtsp_pkg::REG_RETRY:   cfg.retry_period_ms    = csr_data;
               owtsp_pkg::REG_HIGH:    cfg.temp_high_limit    = csr_data;
               owtsp_pkg::REG_LOW:     cfg.temp_low_limit     = csr_data;
               owtsp_pkg::REG_INVALID: cfg.invalid_temp_code  = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_tick(req_data, want);
            expected_ticks.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result transaction %p", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_ticks.pop_front();
               if (rsp_data !== want) begin
                  if (mismatch_count < 10)
                     $display("result mismatch: expected %p actual %p", want, rsp_data);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      pending_count  <= expected_ticks.size();
      bus_phase_view <= phase;
      byte_view      <= pad_byte_num[3:0];
      bit_view       <= bit_index[2:0];
   end
endmodule

/* bench/onewire_temp_sensor_poller_test.sv */
// Testbench top: sensor-emulating tick stimulus, register phases and verdict
module onewire_temp_sensor_poller_test;
   logic      clock = 0;
   logic      reset = 1;
   logic      req_valid = 0;
   logic      req_stall;
   owtsp_pkg::req_type req_data = '0;
   logic      rsp_valid;
   logic      rsp_stall = 0;
   owtsp_pkg::rsp_type rsp_data;
   logic      csr_write = 0;
   logic [2:0] csr_index = owtsp_pkg::REG_TICKS;
   logic [15:0] csr_data = '0;

   int        mismatch_count, pending_count;
   owtsp_pkg::phase_type bus_phase_view;
   logic [3:0] byte_view;
   logic [2:0] bit_view;

   bit        no_idle = 0;
   bit        stall_burst_done = 0;
   int        results_taken = 0;
   owtsp_pkg::phase_type last_seen_phase = owtsp_pkg::PH_IDLE;
   bit        sensor_absent, sensor_stuck;
   bit [7:0]  scratchpad[9];

   always #4 clock = ~clock;

   onewire_temp_sensor_poller u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   onewire_temp_sensor_poller_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count),
      .bus_phase_view(bus_phase_view), .byte_view(byte_view), .bit_view(bit_view)
   );

   function automatic bit [7:0] dallas_crc8(input bit [7:0] pad[9]);
      bit [7:0] crc;
      crc = 0;
      for (int i = 0; i < 8; i++)
         for (int b = 0; b < 8; b++)
            crc = (crc[0] ^ pad[i][b]) ? ((crc >> 1) ^ owtsp_pkg::CRC_POLY) : (crc >> 1);
      return crc;
   endfunction

   task automatic load_sensor();
      bit [15:0] raw;
      sensor_absent = ($urandom_range(0, 7) == 0);
      sensor_stuck  = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 7))
         0: raw = 16'h8000;
         1: raw = 16'h7FFF;
         2: raw = 16'($urandom());
         3: raw = 16'(32'hFFFF - $urandom_range(0, 40));
         default: raw = 16'($urandom_range(0, 2880) - 880);
      endcase
      scratchpad[0] = raw[7:0];
      scratchpad[1] = raw[15:8];
      for (int i = 2; i < 8; i++) scratchpad[i] = 8'($urandom());
      scratchpad[8] = dallas_crc8(scratchpad);
      if ($urandom_range(0, 7) == 0) scratchpad[8] ^= 8'($urandom_range(1, 255));
   endtask

   function automatic bit line_for(input owtsp_pkg::phase_type ph);
      case (ph)
         owtsp_pkg::PH_RST_WAIT:
            return sensor_absent ? 1'b1 : ($urandom_range(0, 3) == 0);
         owtsp_pkg::PH_RST_HOLD:
            return sensor_stuck ? 1'b0 : ($urandom_range(0, 15) == 0);
         owtsp_pkg::PH_RD_DATA:  return scratchpad[byte_view][bit_view];
         default:     return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic send_ticks(input int count, input bit directed);
      int gap;
      owtsp_pkg::req_type item;
      for (int i = 0; i < count; i++) begin
         gap = no_idle ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         if (bus_phase_view == owtsp_pkg::PH_RST_LOW &&
             last_seen_phase != owtsp_pkg::PH_RST_LOW) load_sensor();
         last_seen_phase = bus_phase_view;
         item.line_level = directed ? i[0] : line_for(bus_phase_view);
         item.tank_level = directed ? i[1] : ($urandom_range(0, 15) == 0 ?
                                              ~req_data.tank_level : req_data.tank_level);
         req_valid <= 1;
         req_data  <= item;
         @(posedge clock);
         while (req_stall) @(posedge clock);
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_setting(input logic [15:0] ticks, wait_ms, retry, high, low, code,
                              input int count);
      drain();
      write_reg(owtsp_pkg::REG_TICKS, ticks);
      write_reg(owtsp_pkg::REG_WAIT, wait_ms);
      write_reg(owtsp_pkg::REG_RETRY, retry);
      write_reg(owtsp_pkg::REG_HIGH, high);
      write_reg(owtsp_pkg::REG_LOW, low);
      write_reg(owtsp_pkg::REG_INVALID, code);
      no_idle = ($urandom_range(0, 2) == 0);
      send_ticks(count, 0);
   endtask

   initial begin
      load_sensor();
      repeat (6) @(posedge clock);
      reset <= 0;
      send_ticks(24, 1);
      send_ticks(226, 0);
      run_setting(16'd1, 16'd1, 16'd1, 16'h7FFF, 16'h8000, 16'h7FFF, 300);
      run_setting(16'd0, 16'd0, 16'd0, 16'd1250, -16'sd550, 16'h8000, 300);
      run_setting(16'd3, 16'd2, 16'd5, 16'd0, 16'd0, 16'd5, 200);
      run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 50);
      run_setting(16'd1, 16'd1, 16'd2, 16'($urandom_range(0, 1500)),
                  16'(0 - $urandom_range(0, 900)), 16'($urandom()), 150);
      drain();
      if (mismatch_count == 0)
         $display("onewire_temp_sensor_poller: match");
      else
         $display("onewire_temp_sensor_poller: mismatch");
      $finish;
   end

   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 10);
         if (!stall_burst_done && results_taken >= 200) begin
            hold = 400;
            stall_burst_done = 1;
         end
         if (hold != 0) begin
            rsp_stall <= 1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
      end
   end

   initial begin
      #32000000;
      $display("onewire_temp_sensor_poller: mismatch");
      $finish;
   end
endmodule
